// ===== rtl/core/rng_pkg.sv =====
`default_nettype none
package rng_pkg;

  // default sizes
  localparam int RNG_SAMPLE_BITS = 24;
  localparam int RNG_COEF_BITS   = 16;

  // register reset values, truncated to the configured widths where they are used
  localparam int THR_RESET   = 83886;
  localparam int ALPHA_RESET = 65262;
  localparam int STEP_RESET  = 273;
  localparam int BETA_RESET  = 65522;
  localparam int CHAN_RESET  = 2;

  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_ALPHA     = 3'd1,
    REG_ATTACK    = 3'd2,
    REG_BETA      = 3'd3,
    REG_CHANNELS  = 3'd4
  } cfg_reg_t;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_SQL  = 16'h0002,
    S_SQR  = 16'h0004,
    S_PLO  = 16'h0008,
    S_PHI  = 16'h0010,
    S_MLO  = 16'h0020,
    S_MHI  = 16'h0040,
    S_THR  = 16'h0080,
    S_PWR  = 16'h0100,
    S_CMP  = 16'h0200,
    S_GAIN = 16'h0400,
    S_GUPD = 16'h0800,
    S_OUTL = 16'h1000,
    S_OUTR = 16'h2000,
    S_FIN  = 16'h4000,
    S_DONE = 16'h8000
  } rng_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/rng_cfg.sv =====
`default_nettype none
module rng_cfg import rng_pkg::*; #(
  parameter int SAMPLE_BITS = RNG_SAMPLE_BITS,
  parameter int COEF_BITS   = RNG_COEF_BITS,
  parameter int CFG_W       = (SAMPLE_BITS - 1 > COEF_BITS + 1) ? SAMPLE_BITS - 1 : COEF_BITS + 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [REG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_wdata,
  output logic [SAMPLE_BITS-2:0]      thr,
  output logic [COEF_BITS-1:0]        alpha,
  output logic [COEF_BITS:0]          step,
  output logic [COEF_BITS-1:0]        beta,
  output logic                        two_ch
);

  localparam int TW = SAMPLE_BITS - 1;
  localparam int C  = COEF_BITS;
  localparam int GW = COEF_BITS + 1;
  localparam logic [GW-1:0] GAIN_ONE = {1'b1, {C{1'b0}}};

  logic [TW-1:0] thr_r;
  logic [C-1:0]  alpha_r;
  logic [GW-1:0] step_r;
  logic [C-1:0]  beta_r;
  logic [1:0]    chan_r;
  logic [GW-1:0] step_raw;

  // attack fractions above one act as one
  assign step_raw = cfg_wdata[GW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= TW'(THR_RESET);
      alpha_r <= C'(ALPHA_RESET);
      step_r  <= GW'(STEP_RESET);
      beta_r  <= C'(BETA_RESET);
      chan_r  <= 2'(CHAN_RESET);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr_r   <= cfg_wdata[TW-1:0];
        REG_ALPHA:     alpha_r <= cfg_wdata[C-1:0];
        REG_ATTACK:    step_r  <= (step_raw > GAIN_ONE) ? GAIN_ONE : step_raw;
        REG_BETA:      beta_r  <= cfg_wdata[C-1:0];
        REG_CHANNELS:  chan_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign thr    = thr_r;
  assign alpha  = alpha_r;
  assign step   = step_r;
  assign beta   = beta_r;
  assign two_ch = chan_r[1];

endmodule
`default_nettype wire

// ===== rtl/core/rng_mul.sv =====
`default_nettype none
module rng_mul #(
  parameter int W = 24
) (
  input  wire logic           clk,
  input  wire logic [W-1:0]   a,
  input  wire logic [W-1:0]   b,
  output logic [2*W-1:0]      p
);

  logic [2*W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ===== rtl/core/rng_core.sv =====
`default_nettype none
module rng_core import rng_pkg::*; #(
  parameter int SAMPLE_BITS = RNG_SAMPLE_BITS,
  parameter int COEF_BITS   = RNG_COEF_BITS,
  parameter int MW          = (SAMPLE_BITS > COEF_BITS + 1) ? SAMPLE_BITS : COEF_BITS + 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_left,
  input  wire logic [SAMPLE_BITS-1:0] in_right,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [SAMPLE_BITS-1:0]      out_left,
  output logic [SAMPLE_BITS-1:0]      out_right,
  output logic                        out_gate,
  output logic [COEF_BITS:0]          out_gain,
  input  wire logic [SAMPLE_BITS-2:0] thr,
  input  wire logic [COEF_BITS-1:0]   alpha,
  input  wire logic [COEF_BITS:0]     step,
  input  wire logic [COEF_BITS-1:0]   beta,
  input  wire logic                   two_ch,
  output logic [MW-1:0]               mul_a,
  output logic [MW-1:0]               mul_b,
  input  wire logic [2*MW-1:0]        mul_p
);

  localparam int S  = SAMPLE_BITS;
  localparam int C  = COEF_BITS;
  localparam int GW = C + 1;
  localparam int PW = 2 * S - 1;   // power, Q1.(2S-2)
  localparam int TW = 2 * S - 2;   // threshold squared
  localparam int AW = 2 * S + C;   // blend accumulator
  localparam logic [GW-1:0] GAIN_ONE = {1'b1, {C{1'b0}}};

  rng_state_t state_r, state_nxt;

  logic [S-1:0]  mag_l_r, mag_r_r, raw_r_r;
  logic          neg_l_r, neg_r_r;
  logic [PW-1:0] ms_r;
  logic [AW-1:0] acc_r;
  logic [PW-1:0] power_r;
  logic [TW-1:0] thr2_r;
  logic          open_r;
  logic [GW-1:0] gain_r;
  logic [S-1:0]  res_l_r, res_r_r;
  logic          out_valid_r;
  logic [S-1:0]  out_left_r, out_right_r;
  logic          out_gate_r;
  logic [GW-1:0] out_gain_r;

  logic [S-1:0]  mag_l_in, mag_r_in;
  logic [GW-1:0] one_m_alpha, one_m_gain;
  logic [PW:0]   ms_sum;
  logic [2*C+1:0] att_rnd;
  logic [C+1:0]  gain_sum;
  logic [GW-1:0] gain_nxt;
  logic          load;

  function automatic logic [S-1:0] scale(input logic [2*MW-1:0] p, input logic neg);
    logic [S+GW-1:0] t;
    logic [S:0]      r;
    logic [S:0]      lim;
    t = p[S+GW-1:0] + ((S+GW)'(1) << (C - 1));
    r = t[S+GW-1:C];
    if (neg) begin
      lim = (S+1)'(1) << (S - 1);
      if (r > lim) r = lim;
      scale = ~r[S-1:0] + 1'b1;
    end else begin
      lim = ((S+1)'(1) << (S - 1)) - 1'b1;
      if (r > lim) r = lim;
      scale = r[S-1:0];
    end
  endfunction

  assign mag_l_in = in_left[S-1]  ? (~in_left + 1'b1)  : in_left;
  assign mag_r_in = in_right[S-1] ? (~in_right + 1'b1) : in_right;
  assign one_m_alpha = GAIN_ONE - {1'b0, alpha};
  assign one_m_gain  = GAIN_ONE - gain_r;
  assign ms_sum      = {1'b0, ms_r} + {1'b0, mul_p[PW-1:0]};

  // attack increment rounds up, release rounds down
  assign att_rnd  = mul_p[2*C+1:0] + (2*C+2)'(GAIN_ONE - 1'b1);
  assign gain_sum = {1'b0, gain_r} + att_rnd[2*C+1:C];
  always_comb begin
    if (open_r) begin
      gain_nxt = (gain_sum > {1'b0, GAIN_ONE}) ? GAIN_ONE : gain_sum[GW-1:0];
    end else begin
      gain_nxt = mul_p[2*C:C];
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign load     = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // shared multiplier operand select; the product is registered and lands in the next cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQL: begin
        mul_a = MW'(mag_l_r);
        mul_b = MW'(mag_l_r);
      end
      S_SQR: begin
        mul_a = MW'(mag_r_r);
        mul_b = MW'(mag_r_r);
      end
      S_PLO: begin
        mul_a = MW'(power_r[S-1:0]);
        mul_b = MW'(alpha);
      end
      S_PHI: begin
        mul_a = MW'(power_r[PW-1:S]);
        mul_b = MW'(alpha);
      end
      S_MLO: begin
        mul_a = MW'(ms_r[S-1:0]);
        mul_b = MW'(one_m_alpha);
      end
      S_MHI: begin
        mul_a = MW'(ms_r[PW-1:S]);
        mul_b = MW'(one_m_alpha);
      end
      S_THR: begin
        mul_a = MW'(thr);
        mul_b = MW'(thr);
      end
      S_GAIN: begin
        mul_a = open_r ? MW'(step) : MW'(gain_r);
        mul_b = open_r ? MW'(one_m_gain) : MW'(beta);
      end
      S_OUTL: begin
        mul_a = MW'(mag_l_r);
        mul_b = MW'(gain_r);
      end
      S_OUTR: begin
        mul_a = MW'(mag_r_r);
        mul_b = MW'(gain_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_SQL;
      S_SQL:  state_nxt = S_SQR;
      S_SQR:  state_nxt = S_PLO;
      S_PLO:  state_nxt = S_PHI;
      S_PHI:  state_nxt = S_MLO;
      S_MLO:  state_nxt = S_MHI;
      S_MHI:  state_nxt = S_THR;
      S_THR:  state_nxt = S_PWR;
      S_PWR:  state_nxt = S_CMP;
      S_CMP:  state_nxt = S_GAIN;
      S_GAIN: state_nxt = S_GUPD;
      S_GUPD: state_nxt = S_OUTL;
      S_OUTL: state_nxt = S_OUTR;
      S_OUTR: state_nxt = S_FIN;
      S_FIN:  state_nxt = S_DONE;
      S_DONE: if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      power_r     <= '0;
      gain_r      <= GAIN_ONE;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_PWR) begin
        power_r <= PW'((acc_r + (AW'(1) << (C - 1))) >> C);
      end
      if (state_r == S_GUPD) begin
        gain_r <= gain_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        mag_l_r <= mag_l_in;
        mag_r_r <= mag_r_in;
        neg_l_r <= in_left[S-1];
        neg_r_r <= in_right[S-1];
        raw_r_r <= in_right;
      end
      S_SQR:  ms_r   <= mul_p[PW-1:0];
      S_PLO:  if (two_ch) ms_r <= ms_sum[PW:1];
      S_PHI:  acc_r  <= AW'(mul_p);
      S_MLO:  acc_r  <= acc_r + (AW'(mul_p) << S);
      S_MHI:  acc_r  <= acc_r + AW'(mul_p);
      S_THR:  acc_r  <= acc_r + (AW'(mul_p) << S);
      S_PWR:  thr2_r <= mul_p[TW-1:0];
      S_CMP:  open_r <= (power_r >= PW'(thr2_r));
      S_OUTR: res_l_r <= scale(mul_p, neg_l_r);
      S_FIN:  res_r_r <= two_ch ? scale(mul_p, neg_r_r) : raw_r_r;
      default: ;
    endcase
    if (load) begin
      out_left_r  <= res_l_r;
      out_right_r <= res_r_r;
      out_gate_r  <= open_r;
      out_gain_r  <= gain_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;
  assign out_gate  = out_gate_r;
  assign out_gain  = out_gain_r;

`ifndef SYNTH
  a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= GAIN_ONE) else $error("gain above unity");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_SQL))
    else $error("accepted request did not start the sequence");

  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GUPD && !open_r) |=> (gain_r <= $past(gain_r)))
    else $error("gain rose while gate closed");

  a_attack: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GUPD && open_r) |=> (gain_r >= $past(gain_r)))
    else $error("gain fell while gate open");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r) else $error("result load lost");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/rms_noise_gate.sv =====
`default_nettype none
// RMS noise gate for stereo frames of signed Q1.(SAMPLE_BITS-1) samples. Each frame
// updates a smoothed power estimate (squared RMS) from the mean square of the active
// channels, opens the gate when that power is at or above threshold_level squared,
// moves the gain toward unity (attack) or decays it by release_beta (release), and
// scales the active samples by the new gain with rounding and saturation. All
// products go through one shared multiplier, max(SAMPLE_BITS, COEF_BITS+1) bits
// per operand, under a sequencer that runs ten multiplier passes plus compare,
// update and hand-off steps per frame, and takes a new request only while idle. A
// finished result sits in an output register, so a new request is taken while it
// waits. Coefficients are written in their fixed-point form through the cfg_ port;
// the user must write them only while the block is idle; the block does not enforce it.
module rms_noise_gate import rng_pkg::*; #(
  parameter int SAMPLE_BITS = RNG_SAMPLE_BITS,
  parameter int COEF_BITS   = RNG_COEF_BITS,
  parameter int CFG_W       = (SAMPLE_BITS - 1 > COEF_BITS + 1) ? SAMPLE_BITS - 1 : COEF_BITS + 1,
  parameter int IN_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  parameter int OUT_W       = ((2 * SAMPLE_BITS + COEF_BITS + 2 + 7) / 8) * 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_W-1:0]      in_tdata,   // in_left, in_right
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [OUT_W-1:0]          out_tdata,  // out_left, out_right, gate_open, gain_now
  input  wire logic                 cfg_wr_en,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int S  = SAMPLE_BITS;
  localparam int C  = COEF_BITS;
  localparam int MW = (S > C + 1) ? S : C + 1;

  logic [S-2:0]    thr;
  logic [C-1:0]    alpha, beta;
  logic [C:0]      step;
  logic            two_ch;
  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] mul_p;
  logic [S-1:0]    out_left, out_right;
  logic            out_gate;
  logic [C:0]      out_gain;

  rng_cfg #(
    .SAMPLE_BITS(S),
    .COEF_BITS  (C),
    .CFG_W      (CFG_W)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .thr      (thr),
    .alpha    (alpha),
    .step     (step),
    .beta     (beta),
    .two_ch   (two_ch)
  );

  rng_mul #(
    .W(MW)
  ) u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (mul_p)
  );

  rng_core #(
    .SAMPLE_BITS(S),
    .COEF_BITS  (C),
    .MW         (MW)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_left  (in_tdata[S-1:0]),
    .in_right (in_tdata[2*S-1:S]),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_left (out_left),
    .out_right(out_right),
    .out_gate (out_gate),
    .out_gain (out_gain),
    .thr      (thr),
    .alpha    (alpha),
    .step     (step),
    .beta     (beta),
    .two_ch   (two_ch),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .mul_p    (mul_p)
  );

  assign out_tdata = OUT_W'({out_gain, out_gate, out_right, out_left});

endmodule
`default_nettype wire
